// ===== rtl/core/bmp24_stream_deframer_top_macros.svh =====
// Assertion helpers shared by the deframer RTL.
`ifndef BMP24_STREAM_DEFRAMER_TOP_MACROS_SVH
`define BMP24_STREAM_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BMP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bmp24sd_pkg.sv =====
package bmp24sd_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // width/height registers must hold the maximum itself
    localparam int DIM_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

    localparam logic [7:0] MAGIC_B = 8'h42;
    localparam logic [7:0] MAGIC_M = 8'h4D;

    localparam logic [1:0] KIND_PIXEL     = 2'd0;
    localparam logic [1:0] KIND_BAD_MAGIC = 2'd1;
    localparam logic [1:0] KIND_BAD_GEOM  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        top_down;
        logic        last_pixel;
    } bmp24sd_res_t;

endpackage

// ===== rtl/core/bmp24_stream_deframer_top.sv =====
// 24-bit BMP byte-stream deframer. One file byte enters per item on the s_ side
// (s_tuser high marks byte 0 of a new file and restarts the parse); the header
// magic, data offset, width and height are checked, bytes up to the data
// offset are skipped, and every blue-green-red triple leaves as one pixel item
// on the m_ side tagged with column and row, m_tlast on the image's final pixel.
// Row padding of (width mod 4) bytes is dropped. A header error gives a single
// item with m_tuser set to the error kind and zero data, after which bytes are
// dropped until the next file start; bytes after the last pixel are dropped too.
// Throughput is one byte per clock while s_tready is high: each byte costs a single
// pass through the parser logic into the output buffer. This two-entry buffer keeps
// s_tready high while one result waits on a stalled m_ side; a second one drops it.
`include "bmp24_stream_deframer_top_macros.svh"

module bmp24_stream_deframer_top
    import bmp24sd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tuser,   // [0] file_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // red, green, blue, column, row, top_down, zero fill
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last_pixel
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PIXEL  = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;

    localparam logic [30:0] POS_OFFSET_END = 31'd13;
    localparam logic [30:0] POS_WIDTH_END  = 31'd21;
    localparam logic [30:0] POS_HEIGHT_END = 31'd25;
    localparam logic [30:0] HDR_LEN        = 31'd26;

    logic [2:0]       phase_reg, phase_next;
    logic [30:0]      pos_reg, pos_next;
    logic [23:0]      shift_reg, shift_next;
    logic [30:0]      offset_reg, offset_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [HGT_W-1:0] height_reg, height_next;
    logic             neg_reg, neg_next;
    logic [11:0]      col_reg, col_next;
    logic [11:0]      row_reg, row_next;
    logic [1:0]       comp_reg, comp_next;
    logic [7:0]       blue_reg, blue_next;
    logic [7:0]       green_reg, green_next;
    logic [1:0]       pad_reg, pad_next;

    bmp24sd_res_t out_reg, skid_reg, res;
    logic         out_valid_reg, skid_valid_reg;
    logic         res_valid;
    logic         accept;

    // current state as seen by this byte (file start restarts the parse)
    logic [2:0]  cur_phase;
    logic [30:0] cur_pos;
    logic [23:0] cur_shift;
    logic [11:0] cur_col;
    logic [11:0] cur_row;
    logic [1:0]  cur_comp;

    logic [31:0]      field;
    logic [31:0]      mag;
    logic [30:0]      pos_inc;
    logic             col_end;
    logic             row_end;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    assign cur_phase = s_tuser ? PH_HEADER : phase_reg;
    assign cur_pos   = s_tuser ? 31'd0 : pos_reg;
    assign cur_shift = s_tuser ? 24'd0 : shift_reg;
    assign cur_col   = s_tuser ? 12'd0 : col_reg;
    assign cur_row   = s_tuser ? 12'd0 : row_reg;
    assign cur_comp  = s_tuser ? 2'd0 : comp_reg;

    // only the upper three bytes of the field survive to the next byte
    assign field   = {s_tdata, cur_shift};
    assign mag     = field[31] ? (32'd0 - field) : field;
    assign pos_inc = cur_pos + 31'd1;
    assign col_end = ({1'b0, cur_col} + 13'd1) == DIM_W'(width_reg);
    assign row_end = ({1'b0, cur_row} + 13'd1) == HGT_W'(height_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        shift_next  = shift_reg;
        offset_next = offset_reg;
        width_next  = width_reg;
        height_next = height_reg;
        neg_next    = neg_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        comp_next   = comp_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        pad_next    = pad_reg;
        res         = '0;
        res_valid   = 1'b0;

        if (accept)
        begin
            phase_next = cur_phase;
            pos_next   = cur_pos;
            shift_next = cur_shift;
            col_next   = cur_col;
            row_next   = cur_row;
            comp_next  = cur_comp;

            case (cur_phase)
                PH_HEADER:
                begin
                    if ((cur_pos == 31'd0 && s_tdata != MAGIC_B) ||
                        (cur_pos == 31'd1 && s_tdata != MAGIC_M))
                    begin
                        res_valid  = 1'b1;
                        res.kind   = KIND_BAD_MAGIC;
                        phase_next = PH_ERROR;
                    end
                    else
                    begin
                        shift_next = field[31:8];
                        pos_next   = pos_inc;
                        if (cur_pos == POS_OFFSET_END)
                        begin
                            offset_next = field[30:0];
                            if (field[31] || field < 32'd26)
                            begin
                                res_valid  = 1'b1;
                                res.kind   = KIND_BAD_GEOM;
                                phase_next = PH_ERROR;
                            end
                        end
                        else if (cur_pos == POS_WIDTH_END)
                        begin
                            if (field[31] || field == 32'd0 || field > 32'(MAX_WIDTH))
                            begin
                                res_valid  = 1'b1;
                                res.kind   = KIND_BAD_GEOM;
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                width_next = field[DIM_W-1:0];
                            end
                        end
                        else if (cur_pos == POS_HEIGHT_END)
                        begin
                            if (mag == 32'd0 || mag > 32'(MAX_HEIGHT))
                            begin
                                res_valid  = 1'b1;
                                res.kind   = KIND_BAD_GEOM;
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                height_next = mag[HGT_W-1:0];
                                neg_next    = field[31];
                                pos_next    = HDR_LEN;
                                phase_next  = (offset_reg == HDR_LEN) ? PH_PIXEL : PH_SKIP;
                            end
                        end
                    end
                end

                PH_SKIP:
                begin
                    pos_next = pos_inc;
                    if (pos_inc == offset_reg)
                    begin
                        phase_next = PH_PIXEL;
                    end
                end

                PH_PIXEL:
                begin
                    if (cur_comp == 2'd0)
                    begin
                        blue_next = s_tdata;
                        comp_next = 2'd1;
                    end
                    else if (cur_comp == 2'd1)
                    begin
                        green_next = s_tdata;
                        comp_next  = 2'd2;
                    end
                    else
                    begin
                        comp_next      = 2'd0;
                        res_valid      = 1'b1;
                        res.kind       = KIND_PIXEL;
                        res.red        = s_tdata;
                        res.green      = green_reg;
                        res.blue       = blue_reg;
                        res.column     = cur_col;
                        res.row        = cur_row;
                        res.top_down   = neg_reg;
                        res.last_pixel = col_end && row_end;
                        if (col_end && row_end)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (col_end)
                        begin
                            col_next = 12'd0;
                            row_next = cur_row + 12'd1;
                            pad_next = width_reg[1:0];
                            if (width_reg[1:0] != 2'd0)
                            begin
                                phase_next = PH_PAD;
                            end
                        end
                        else
                        begin
                            col_next = cur_col + 12'd1;
                        end
                    end
                end

                PH_PAD:
                begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_reg == 2'd1)
                    begin
                        phase_next = PH_PIXEL;
                    end
                end

                default:
                begin
                    // done or error: drop bytes until the next file start
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            shift_reg  <= '0;
            offset_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            neg_reg    <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            comp_reg   <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
            pad_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            shift_reg  <= shift_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            neg_reg    <= neg_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            comp_reg   <= comp_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            pad_reg    <= pad_next;
        end
    end

    // output register plus one skid entry; skid only fills while output stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_valid;
            end
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last_pixel;
    assign m_tdata  = {7'd0, out_reg.top_down, out_reg.row, out_reg.column,
                       out_reg.blue, out_reg.green, out_reg.red};

    `BMP_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid entry holds an item while output register is empty")
    `BMP_ASSERT_IMP(a_error_zero_data, m_tvalid && m_tuser != KIND_PIXEL,
        m_tdata == 56'd0 && !m_tlast, "error item carries nonzero data")
    `BMP_ASSERT_IMP(a_pad_nonzero, phase_reg == PH_PAD, pad_reg != 2'd0,
        "padding phase with no padding bytes left")
    `BMP_ASSERT_NXT(a_stall_fills_skid, out_valid_reg && !m_tready && res_valid,
        skid_valid_reg && !s_tready, "result lost while output stalled")

endmodule

// ===== dv/tb_bmp24_stream_deframer_top.sv =====
`timescale 1ns / 1ps

module tb_bmp24_stream_deframer_top;
    import bmp24sd_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_BYTES  = 150;

    typedef enum logic [2:0] {
        PS_HEADER,
        PS_SKIP,
        PS_PIXEL,
        PS_PAD,
        PS_DONE,
        PS_ERROR
    } parse_state_t;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SNK,
        IDLE_BOTH
    } idle_mode_t;

    // how a stimulus item is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_RES
    } chk_t;

    typedef struct packed {
        logic [7:0]   b;
        logic         st;
        chk_t         chk;
        bmp24sd_res_t res;
    } stim_item_t;

    localparam bmp24sd_res_t RES_NONE  = '0;
    localparam bmp24sd_res_t RES_MAGIC = '{kind: KIND_BAD_MAGIC, default: '0};
    localparam bmp24sd_res_t RES_GEOM  = '{kind: KIND_BAD_GEOM, default: '0};

    localparam stim_item_t DIR_TAB [23] = '{
        '{8'h58,   1'b0, CHK_RES,   RES_MAGIC},  // no file start after reset
        '{MAGIC_B, 1'b0, CHK_NONE,  RES_NONE},   // dropped after error
        '{MAGIC_B, 1'b1, CHK_NONE,  RES_NONE},
        '{8'h4C,   1'b0, CHK_RES,   RES_MAGIC},  // second magic byte wrong
        '{MAGIC_B, 1'b1, CHK_NONE,  RES_NONE},
        '{MAGIC_M, 1'b0, CHK_NONE,  RES_NONE},
        '{8'hFF,   1'b0, CHK_MODEL, RES_NONE},
        '{8'h00,   1'b0, CHK_MODEL, RES_NONE},
        '{8'hA5,   1'b0, CHK_MODEL, RES_NONE},
        '{8'h5A,   1'b0, CHK_MODEL, RES_NONE},
        '{8'hFF,   1'b0, CHK_MODEL, RES_NONE},
        '{8'h00,   1'b0, CHK_MODEL, RES_NONE},
        '{8'h0F,   1'b0, CHK_MODEL, RES_NONE},
        '{8'hF0,   1'b0, CHK_MODEL, RES_NONE},
        '{8'h19,   1'b0, CHK_NONE,  RES_NONE},   // offset 25, just below minimum
        '{8'h00,   1'b0, CHK_NONE,  RES_NONE},
        '{8'h00,   1'b0, CHK_NONE,  RES_NONE},
        '{8'h00,   1'b0, CHK_RES,   RES_GEOM},
        '{8'hFF,   1'b0, CHK_NONE,  RES_NONE},
        '{MAGIC_B, 1'b1, CHK_NONE,  RES_NONE},
        '{MAGIC_M, 1'b0, CHK_NONE,  RES_NONE},
        '{MAGIC_B, 1'b1, CHK_NONE,  RES_NONE},   // restart in mid header
        '{8'h42,   1'b0, CHK_RES,   RES_MAGIC}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // parser state tracked by the predictor
    parse_state_t ps;
    logic [31:0]  hdr_pos;
    logic [31:0]  field_sr;
    logic [31:0]  data_ofs;
    logic [12:0]  img_w;
    logic [12:0]  img_h;
    logic         h_neg;
    logic [11:0]  col_cnt;
    logic [11:0]  row_cnt;
    logic [1:0]   comp_idx;
    logic [7:0]   held_b;
    logic [7:0]   held_g;
    logic [1:0]   pad_left;

    stim_item_t   stim_q [$];
    bmp24sd_res_t pixel_q [$];
    idle_mode_t   rx_mode = IDLE_NONE;
    bit           hold_req = 1'b0;
    int           hold_left = 0;
    int           quiet_cycles = 0;
    int           n_fail = 0;
    int           n_bytes = 0;
    int           n_files = 0;
    int           n_pixels = 0;
    int           n_errors = 0;

    bmp24_stream_deframer_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    function automatic void clear_parser();
        ps       = PS_HEADER;
        hdr_pos  = '0;
        field_sr = '0;
        data_ofs = '0;
        img_w    = '0;
        img_h    = '0;
        h_neg    = 1'b0;
        col_cnt  = '0;
        row_cnt  = '0;
        comp_idx = '0;
        held_b   = '0;
        held_g   = '0;
        pad_left = '0;
    endfunction

    function automatic bit predict_pixel(input logic [7:0] b, input logic st,
                                         output bmp24sd_res_t r);
        logic [31:0] v;
        logic [31:0] mag;
        bit          row_end;
        bit          at_end;
        r = '0;
        if (st)
            clear_parser();
        case (ps)
            PS_HEADER:
            begin
                if ((hdr_pos == 0 && b != MAGIC_B) || (hdr_pos == 1 && b != MAGIC_M))
                begin
                    r.kind = KIND_BAD_MAGIC;
                    ps = PS_ERROR;
                    return 1'b1;
                end
                field_sr = {b, field_sr[31:8]};
                v = field_sr;
                if (hdr_pos == 13)
                begin
                    data_ofs = v;
                    if (v[31] || v < 26)
                    begin
                        r.kind = KIND_BAD_GEOM;
                        ps = PS_ERROR;
                        return 1'b1;
                    end
                end
                else if (hdr_pos == 21)
                begin
                    if (v[31] || v == 0 || v > MAX_WIDTH)
                    begin
                        r.kind = KIND_BAD_GEOM;
                        ps = PS_ERROR;
                        return 1'b1;
                    end
                    img_w = v[12:0];
                end
                else if (hdr_pos == 25)
                begin
                    // most negative height wraps to itself and fails the bound
                    mag = v[31] ? -v : v;
                    if (mag == 0 || mag > MAX_HEIGHT)
                    begin
                        r.kind = KIND_BAD_GEOM;
                        ps = PS_ERROR;
                        return 1'b1;
                    end
                    img_h = mag[12:0];
                    h_neg = v[31];
                    hdr_pos = 26;
                    ps = (data_ofs == 26) ? PS_PIXEL : PS_SKIP;
                    return 1'b0;
                end
                hdr_pos = hdr_pos + 1;
                return 1'b0;
            end
            PS_SKIP:
            begin
                hdr_pos = hdr_pos + 1;
                if (hdr_pos == data_ofs)
                    ps = PS_PIXEL;
                return 1'b0;
            end
            PS_PIXEL:
            begin
                if (comp_idx == 0)
                begin
                    held_b = b;
                    comp_idx = 1;
                    return 1'b0;
                end
                if (comp_idx == 1)
                begin
                    held_g = b;
                    comp_idx = 2;
                    return 1'b0;
                end
                comp_idx = 0;
                row_end = (col_cnt + 13'd1 == img_w);
                at_end  = row_end && (row_cnt + 13'd1 == img_h);
                r.kind       = KIND_PIXEL;
                r.red        = b;
                r.green      = held_g;
                r.blue       = held_b;
                r.column     = col_cnt;
                r.row        = row_cnt;
                r.top_down   = h_neg;
                r.last_pixel = at_end;
                if (at_end)
                    ps = PS_DONE;
                else if (row_end)
                begin
                    col_cnt = '0;
                    row_cnt = row_cnt + 1;
                    pad_left = img_w[1:0];
                    if (pad_left != 0)
                        ps = PS_PAD;
                end
                else
                    col_cnt = col_cnt + 1;
                return 1'b1;
            end
            PS_PAD:
            begin
                pad_left = pad_left - 1;
                if (pad_left == 0)
                    ps = PS_PIXEL;
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // one file: header, skip bytes, rows with padding, a few trailing bytes.
    // cut < 0 keeps it whole; bad_pos 0 or 1 corrupts that magic byte.
    task automatic gen_file(input logic [31:0] ofs, input logic [31:0] wf,
                            input logic [31:0] hf, input int cut, input int bad_pos);
        logic [7:0]  f [$];
        logic [31:0] hmag;
        int          w;
        int          h;
        int          n;
        f.push_back(MAGIC_B);
        f.push_back(MAGIC_M);
        repeat (8) f.push_back(rand_byte());
        for (int i = 0; i < 4; i++) f.push_back(ofs[8*i +: 8]);
        repeat (4) f.push_back(rand_byte());
        for (int i = 0; i < 4; i++) f.push_back(wf[8*i +: 8]);
        for (int i = 0; i < 4; i++) f.push_back(hf[8*i +: 8]);
        if (bad_pos >= 0)
        begin
            f[bad_pos] = f[bad_pos] ^ 8'($urandom_range(1, 255));
            cut = 4;
        end
        hmag = hf[31] ? -hf : hf;
        if (!ofs[31] && ofs >= 26 && !wf[31] && wf != 0 && wf <= MAX_WIDTH &&
            hmag != 0 && hmag <= MAX_HEIGHT)
        begin
            w = wf;
            h = hmag;
            repeat (ofs - 26) f.push_back(rand_byte());
            repeat (h)
            begin
                repeat (3 * w) f.push_back(rand_byte());
                repeat (w % 4) f.push_back(rand_byte());
            end
        end
        repeat ($urandom_range(0, 2)) f.push_back(rand_byte());
        n = (cut < 0 || cut > f.size()) ? f.size() : cut;
        for (int i = 0; i < n; i++) stim_q.push_back('{f[i], i == 0, CHK_MODEL, RES_NONE});
        n_files++;
    endtask

    task automatic gen_small_files(input int target);
        logic [31:0] ofs;
        logic [31:0] wf;
        logic [31:0] hf;
        int          h;
        int          cut;
        int          bad_pos;
        while (stim_q.size() < target)
        begin
            ofs = 26 + ($urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
            wf  = $urandom_range(1, 9);
            h   = $urandom_range(1, 3);
            hf  = $urandom_range(0, 1) ? -h : h;
            cut = -1;
            bad_pos = -1;
            case ($urandom_range(0, 19))
                0:  ofs = $urandom_range(0, 25);
                1:  ofs = {1'b1, 31'($urandom)};
                2:  wf = 0;
                3:  wf = MAX_WIDTH + 1;
                4:  wf = {1'b1, 31'($urandom)};
                5:  hf = 0;
                6:  hf = $urandom_range(0, 1) ? -(MAX_HEIGHT + 1) : MAX_HEIGHT + 1;
                7:  hf = 32'h8000_0000;
                8:  cut = $urandom_range(1, 40);
                9:  bad_pos = $urandom_range(0, 1);
                10:
                begin
                    // stray bytes, sometimes with a spurious file start
                    repeat ($urandom_range(1, 4))
                        stim_q.push_back('{rand_byte(), 1'($urandom_range(0, 1)),
                                           CHK_MODEL, RES_NONE});
                end
                default: ;
            endcase
            gen_file(ofs, wf, hf, cut, bad_pos);
        end
    endtask

    // drains stim_q; predicts each item at the edge where it is taken
    task automatic send_all(input idle_mode_t mode);
        stim_item_t   it;
        bmp24sd_res_t r;
        bit           got;
        while (stim_q.size() != 0)
        begin
            it = stim_q.pop_front();
            if (mode == IDLE_SRC || mode == IDLE_BOTH)
                while ($urandom_range(0, 99) < ((mode == IDLE_SRC) ? 77 : 8))
                begin
                    s_tvalid <= 1'b0;
                    @(posedge clk);
                end
            s_tvalid <= 1'b1;
            s_tdata  <= it.b;
            s_tuser  <= it.st;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            got = predict_pixel(it.b, it.st, r);
            n_bytes++;
            if (it.chk == CHK_MODEL && got)
                pixel_q.push_back(r);
            else if (it.chk == CHK_RES)
                pixel_q.push_back(it.res);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                IDLE_SNK:  m_tready <= ($urandom_range(0, 99) >= 77);
                IDLE_BOTH: m_tready <= ($urandom_range(0, 99) >= 8);
                default:   m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin : out_mon
        bmp24sd_res_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (m_tvalid && m_tready)
            begin
                if (pixel_q.size() == 0)
                begin
                    $error("result item with nothing expected: kind %0d", m_tuser);
                    n_fail++;
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (want.kind == KIND_PIXEL)
                        n_pixels++;
                    else
                        n_errors++;
                    check_field("kind", want.kind, m_tuser);
                    check_field("red", want.red, m_tdata[7:0]);
                    check_field("green", want.green, m_tdata[15:8]);
                    check_field("blue", want.blue, m_tdata[23:16]);
                    check_field("column", want.column, m_tdata[35:24]);
                    check_field("row", want.row, m_tdata[47:36]);
                    check_field("top_down", want.top_down, m_tdata[48]);
                    check_field("zero_fill", '0, m_tdata[55:49]);
                    check_field("last_pixel", want.last_pixel, m_tlast);
                end
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $error("no item accepted for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        clear_parser();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TAB[i]) stim_q.push_back(DIR_TAB[i]);
        send_all(IDLE_NONE);

        // full rate; the long output hold-off lands on the widest image.
        // the extreme-size files are cut after their first pixels.
        gen_file(26, MAX_WIDTH, 1, 86, -1);
        gen_file(27, 1, -MAX_HEIGHT, 107, -1);
        gen_small_files(stim_q.size() + PHASE_BYTES);
        hold_req = 1'b1;
        send_all(IDLE_NONE);

        rx_mode = IDLE_SRC;
        gen_small_files(PHASE_BYTES);
        send_all(IDLE_SRC);

        rx_mode = IDLE_SNK;
        gen_small_files(PHASE_BYTES);
        send_all(IDLE_SNK);

        rx_mode = IDLE_BOTH;
        gen_small_files(PHASE_BYTES);
        send_all(IDLE_BOTH);

        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Parsed %0d files in %0d bytes; checked %0d pixels and %0d header errors.",
                 n_files, n_bytes, n_pixels, n_errors);
        $display("Traffic: full rate, sparse input, sparse output, light jitter, one long hold.");
        if (n_fail == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
